### rtl/core/lbp_pkg.sv
// Shared constants, codes and types for the local binary pattern histogram unit.
// No dependencies; imported by every module of the unit but lbp_ram.
`default_nettype none

package lbp_pkg;

   // Field widths fixed by the stream format.
   localparam int CFG_W     = 12;
   localparam int PIX_W     = 8;
   localparam int CODE_W    = 8;
   localparam int POS_OUT_W = 11;
   localparam int BIN_W     = 23;
   localparam int CMD_W     = 2;
   localparam int NBINS     = 256;
   localparam int CSR_IDX_W = 1;

   // Default frame limits.
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 2048;

   // Register reset values.
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   // Command codes of the request word.
   localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_START = 2'd2;

   // Response kinds.
   localparam logic KIND_CODE  = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   // Saturation value of a histogram bin.
   localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

   // Operation on the histogram memory.
   typedef enum logic [1:0] {
      HOP_NONE,
      HOP_COUNT,
      HOP_READ,
      HOP_CLEAR
   } hist_op_type;

   typedef struct packed {
      hist_op_type         op;
      logic [CODE_W-1:0]   addr;
   } hist_req_type;

endpackage

`default_nettype wire

### rtl/core/lbp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read at the address being written returns the old contents. No dependencies.
`default_nettype none

module lbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/core/lbp_window.sv
// Line buffers, 3x3 window and pattern code logic of the LBP unit.
// Depends on lbp_pkg and lbp_ram.
`default_nettype none

module lbp_window
   import lbp_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         px_valid,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] px_col,
   input  wire logic [PIX_W-1:0]             px_data,
   output logic      [CODE_W-1:0]            code
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic             s1_valid_ff;
   logic [CW-1:0]    s1_col_ff;
   logic [PIX_W-1:0] s1_px_ff;

   logic             hit_ff;
   logic [PIX_W-1:0] fwd1_ff;
   logic [PIX_W-1:0] fwd2_ff;

   logic [PIX_W-1:0] q_prev;
   logic [PIX_W-1:0] q_prev2;
   logic [PIX_W-1:0] above1;
   logic [PIX_W-1:0] above2;
   logic             wr_en;

   logic [8:0][PIX_W-1:0] win_ff;
   logic [8:0][PIX_W-1:0] win_in;

   assign wr_en = en && s1_valid_ff;

   // Row above the current one.
   lbp_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_prev (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (en),
      .rd_addr (px_col),
      .rd_data (q_prev)
   );

   // Row two above the current one.
   lbp_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_prev2 (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (above1),
      .rd_en   (en),
      .rd_addr (px_col),
      .rd_data (q_prev2)
   );

   // A pixel in the same column as the one just before (one-pixel rows) reads
   // the buffer in the cycle it is written, so the written words are forwarded.
   assign above1 = hit_ff ? fwd1_ff : q_prev;
   assign above2 = hit_ff ? fwd2_ff : q_prev2;

   // Shift the window left by one column and bring in the new column.
   always_comb begin
      win_in    = win_ff;
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = above2;
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = above1;
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = s1_px_ff;
   end

   // Neighbors at or above the center give a one, left first from the MSB.
   always_comb begin
      code[7] = win_in[3] >= win_in[4];
      code[6] = win_in[0] >= win_in[4];
      code[5] = win_in[1] >= win_in[4];
      code[4] = win_in[2] >= win_in[4];
      code[3] = win_in[5] >= win_in[4];
      code[2] = win_in[8] >= win_in[4];
      code[1] = win_in[7] >= win_in[4];
      code[0] = win_in[6] >= win_in[4];
   end

   // Stage registers, forwarding registers and the window.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= px_valid;
         hit_ff      <= s1_valid_ff && px_valid && (s1_col_ff == px_col);
      end
      if (en) begin
         s1_col_ff <= px_col;
         s1_px_ff  <= px_data;
         fwd1_ff   <= s1_px_ff;
         fwd2_ff   <= above1;
      end
      if (wr_en) begin
         win_ff <= win_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/lbp_hist.sv
// 256-bin code histogram: memory with read-modify-write, forwarding and
// per-bin valid bits so that a clear empties every bin at once. Depends on lbp_pkg and lbp_ram.
`default_nettype none

module lbp_hist
   import lbp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire hist_req_type       req,
   output logic      [BIN_W-1:0]   count
);

   hist_op_type       op_ff;
   logic [CODE_W-1:0] addr_ff;
   logic [NBINS-1:0]  valid_ff;
   logic              last_wr_ff;
   logic [CODE_W-1:0] last_addr_ff;
   logic [BIN_W-1:0]  last_val_ff;

   logic [BIN_W-1:0]  q;
   logic [BIN_W-1:0]  next_val;
   logic              wr_en;

   assign wr_en = en && (op_ff == HOP_COUNT);

   lbp_ram #(
      .WIDTH (BIN_W),
      .DEPTH (NBINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (next_val),
      .rd_en   (en),
      .rd_addr (req.addr),
      .rd_data (q)
   );

   // Current bin value: the previous cycle's write wins, a bin not written
   // since the last clear reads as zero.
   always_comb begin
      if (last_wr_ff && (last_addr_ff == addr_ff)) begin
         count = last_val_ff;
      end else if (valid_ff[addr_ff]) begin
         count = q;
      end else begin
         count = '0;
      end
      next_val = (count == BIN_MAX) ? count : count + 1'b1;
   end

   // Control, valid bits and forwarding registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff      <= HOP_NONE;
         valid_ff   <= '0;
         last_wr_ff <= 1'b0;
      end else if (en) begin
         op_ff      <= req.op;
         last_wr_ff <= (op_ff == HOP_COUNT);
         if (op_ff == HOP_COUNT) begin
            valid_ff[addr_ff] <= 1'b1;
         end else if (op_ff == HOP_CLEAR) begin
            valid_ff <= '0;
         end
      end
      if (en) begin
         addr_ff      <= req.addr;
         last_addr_ff <= addr_ff;
         last_val_ff  <= next_val;
      end
   end

endmodule

`default_nettype wire

### rtl/core/lbp_code_histogram_3x3_unit.sv
// Top level of the 3x3 local binary pattern unit with its code histogram.
// Depends on lbp_pkg, lbp_window and lbp_hist.
//
//  Port group  | Direction | Carries
//  req_*       | in        | tuser: cmd[1:0]; tdata: pixel[7:0], bin_index[15:8]
//  rsp_*       | out       | tuser: kind; tlast: frame_done; tdata: code, center_row,
//              |           |   center_col, bin_count
//  csr_*       | in        | frame_width (index 0), frame_height (index 1)
//
// One word is taken per cycle unless the response port stalls. A result reaches the response port
// through the line buffer read, which registers as the word is taken, then the
// histogram read and then the output register. The histogram read-modify-write
// forwards from the cycle before, so repeated codes need no wait. Reset leaves
// the histogram empty through its valid bits; no clearing pass is needed. A
// stalled response holds the whole pipeline and drops req_tready.
`default_nettype none

module lbp_code_histogram_3x3_unit
   import lbp_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Request stream.
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [15:0]          req_tdata,  // pixel[7:0], bin_index[15:8]
   input  wire logic [CMD_W-1:0]     req_tuser,  // cmd[1:0]
   // Response stream.
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic      [55:0]          rsp_tdata,  // code[7:0], center_row[18:8],
                                                 // center_col[29:19], bin_count[52:30]
   output logic                      rsp_tuser,  // kind
   output logic                      rsp_tlast,  // frame_done
   // Register writes.
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT + 1);
   localparam int XWN = $clog2(MAX_WIDTH + 1);
   localparam int XW  = (XWN > CFG_W) ? XWN : CFG_W;
   localparam int YW  = (RW > CFG_W) ? RW : CFG_W;

   logic [CFG_W-1:0]     width_ff;
   logic [CFG_W-1:0]     height_ff;
   logic [RW-1:0]        row_pos_ff;
   logic [CW-1:0]        col_pos_ff;

   logic                 en;
   logic                 acc;
   logic [CMD_W-1:0]     cmd;
   logic [PIX_W-1:0]     pixel;
   logic [CODE_W-1:0]    bin_index;

   logic [XW-1:0]        w_cfg;
   logic [XW-1:0]        w_eff;
   logic [YW-1:0]        h_cfg;
   logic [YW-1:0]        h_eff;
   logic [XW-1:0]        c_ext;
   logic [YW-1:0]        r_ext;
   logic                 push;
   logic                 emit;
   logic                 row_end;
   logic                 is_last;

   hist_op_type          s1_op_ff;
   logic [CODE_W-1:0]    s1_bin_ff;
   logic [POS_OUT_W-1:0] s1_row_ff;
   logic [POS_OUT_W-1:0] s1_col_ff;
   logic                 s1_last_ff;

   hist_op_type          s2_op_ff;
   logic [CODE_W-1:0]    s2_code_ff;
   logic [POS_OUT_W-1:0] s2_row_ff;
   logic [POS_OUT_W-1:0] s2_col_ff;
   logic                 s2_last_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_kind_ff;
   logic [CODE_W-1:0]    rsp_code_ff;
   logic [POS_OUT_W-1:0] rsp_row_ff;
   logic [POS_OUT_W-1:0] rsp_col_ff;
   logic [BIN_W-1:0]     rsp_count_ff;
   logic                 rsp_last_ff;

   logic [CODE_W-1:0]    code;
   logic [BIN_W-1:0]     count;
   hist_req_type         hreq;

   // The whole pipeline moves unless a response is waiting.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign acc        = req_tvalid && en;

   assign cmd       = req_tuser;
   assign pixel     = req_tdata[7:0];
   assign bin_index = req_tdata[15:8];

   // Effective frame size and position decode.
   always_comb begin
      w_cfg = XW'(width_ff);
      h_cfg = YW'(height_ff);
      if (w_cfg == '0) begin
         w_eff = XW'(1);
      end else if (w_cfg > XW'(MAX_WIDTH)) begin
         w_eff = XW'(MAX_WIDTH);
      end else begin
         w_eff = w_cfg;
      end
      h_eff   = (h_cfg > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : h_cfg;
      c_ext   = XW'(col_pos_ff);
      r_ext   = YW'(row_pos_ff);
      push    = acc && (cmd == CMD_PUSH) && (r_ext < h_eff);
      row_end = (c_ext + XW'(1)) >= w_eff;
      emit    = (r_ext >= YW'(2)) && (c_ext >= XW'(2)) && (c_ext < w_eff);
      is_last = (r_ext == h_eff - YW'(1)) && (c_ext == w_eff - XW'(1));
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: height_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // Raster position.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff <= '0;
         col_pos_ff <= '0;
      end else if (acc && (cmd == CMD_START)) begin
         row_pos_ff <= '0;
         col_pos_ff <= '0;
      end else if (push) begin
         if (row_end) begin
            col_pos_ff <= '0;
            row_pos_ff <= row_pos_ff + 1'b1;
         end else begin
            col_pos_ff <= col_pos_ff + 1'b1;
         end
      end
   end

   // Line buffers and window.
   lbp_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .px_valid (push),
      .px_col   (col_pos_ff),
      .px_data  (pixel),
      .code     (code)
   );

   // First stage: decide the histogram operation of the word.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_op_ff <= HOP_NONE;
      end else if (en) begin
         if (push && emit) begin
            s1_op_ff <= HOP_COUNT;
         end else if (acc && (cmd == CMD_READ)) begin
            s1_op_ff <= HOP_READ;
         end else if (acc && (cmd == CMD_START)) begin
            s1_op_ff <= HOP_CLEAR;
         end else begin
            s1_op_ff <= HOP_NONE;
         end
      end
      if (en) begin
         s1_bin_ff  <= bin_index;
         s1_row_ff  <= POS_OUT_W'(r_ext - YW'(1));
         s1_col_ff  <= POS_OUT_W'(c_ext - XW'(1));
         s1_last_ff <= is_last;
      end
   end

   assign hreq.op   = s1_op_ff;
   assign hreq.addr = (s1_op_ff == HOP_COUNT) ? code : s1_bin_ff;

   lbp_hist u_hist (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .req   (hreq),
      .count (count)
   );

   // Second stage: carry the code result alongside the histogram access.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_op_ff <= HOP_NONE;
      end else if (en) begin
         s2_op_ff <= s1_op_ff;
      end
      if (en) begin
         s2_code_ff <= code;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= (s2_op_ff == HOP_COUNT) || (s2_op_ff == HOP_READ);
      end
      if (en) begin
         if (s2_op_ff == HOP_READ) begin
            rsp_kind_ff  <= KIND_COUNT;
            rsp_code_ff  <= '0;
            rsp_row_ff   <= '0;
            rsp_col_ff   <= '0;
            rsp_count_ff <= count;
            rsp_last_ff  <= 1'b0;
         end else begin
            rsp_kind_ff  <= KIND_CODE;
            rsp_code_ff  <= s2_code_ff;
            rsp_row_ff   <= s2_row_ff;
            rsp_col_ff   <= s2_col_ff;
            rsp_count_ff <= '0;
            rsp_last_ff  <= s2_last_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_col_ff, rsp_row_ff, rsp_code_ff};

   // A start of frame returns the raster position to the origin.
   assert property (@(posedge clock) disable iff (reset)
      (acc && (cmd == CMD_START)) |=> (row_pos_ff == '0) && (col_pos_ff == '0))
      else $error("position not cleared by start of frame");

   // Only a pattern code can close a frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == KIND_CODE))
      else $error("frame end flagged on a bin count");

   // A bin count carries no code or position.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_COUNT)) |-> (rsp_tdata[29:0] == '0))
      else $error("bin count carries code fields");

   // Results stem only from histogram work that the middle stage held.
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_tvalid)) |-> ($past(s2_op_ff) == HOP_COUNT || $past(s2_op_ff) == HOP_READ))
      else $error("result without a histogram access");

endmodule

`default_nettype wire
